>>> rtl/core/bns_pkg.sv
// Shared types, codes and the volume-to-duty table of the buzzer note sequencer.
`timescale 1ns / 1ps

package bns_pkg;

  typedef enum logic [2:0] {
    MODE_TICK      = 3'd0,
    MODE_TONE      = 3'd1,
    MODE_LOAD_NOTE = 3'd2,
    MODE_SEQUENCE  = 3'd3,
    MODE_STOP      = 3'd4,
    MODE_MAX_POWER = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_STOPPED   = 2'd0,
    ST_TONE      = 2'd1,
    ST_SEQUENCE  = 2'd2,
    ST_MAX_POWER = 2'd3
  } status_e;

  typedef enum logic {
    CFG_VOLUME     = 1'b0,
    CFG_RATED_FREQ = 1'b1
  } cfg_idx_e;

  localparam logic [3:0]  VOLUME_RESET     = 4'd4;
  localparam logic [15:0] RATED_FREQ_RESET = 16'd4000;
  localparam logic [15:0] REST_FREQ        = 16'd1000;
  // one tick consumes this much of the freq*ms budget
  localparam logic [31:0] TICK_STEP        = 32'd1000;
  localparam logic [5:0]  DUTY_FULL        = 6'd50;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] freq_hz;
    logic [15:0] duration_ms;
    logic [3:0]  tone_volume;
    logic [3:0]  note_index;
    logic [4:0]  sequence_length;
    logic        repeat_sequence;
  } cmd_t;

  // Volume index to duty percent; indexes above 8 saturate.
  function automatic logic [5:0] duty_of(input logic [3:0] vol);
    logic [5:0] duty;
    case (vol)
      4'd0:    duty = 6'd0;
      4'd1:    duty = 6'd3;
      4'd2:    duty = 6'd5;
      4'd3:    duty = 6'd8;
      4'd4:    duty = 6'd10;
      4'd5:    duty = 6'd14;
      4'd6:    duty = 6'd20;
      4'd7:    duty = 6'd28;
      default: duty = DUTY_FULL;
    endcase
    return duty;
  endfunction

endpackage

>>> rtl/core/buzzer_note_sequencer.sv
// Buzzer note sequencer: command register, playback state, note memory and result register.
`timescale 1ns / 1ps

//  Channel  Signals                                   Direction
//  cmd      in_valid_i / in_ready_o + command fields  in
//  result   out_valid_o / out_ready_i + PWM fields    out
//  cfg      cfg_valid_i / cfg_ready_o, index, data    in
//
//  One command per cycle unless the result stalls: a transfer lands in the command
//  register, the next state and the result are formed from it combinationally
//  and land in the result register, which follows the command register.
//  A stalled result holds the command register; in_ready_o follows out_ready_i then.
//  Reset clears playback state and loads volume 4, rated frequency 4000 Hz.
//  The note memory is not cleared; its entries are defined once loaded.

module buzzer_note_sequencer #(
  parameter int NOTE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [15:0] freq_hz_i,
  input  logic [15:0] duration_ms_i,
  input  logic [3:0]  tone_volume_i,
  input  logic [3:0]  note_index_i,
  input  logic [4:0]  sequence_length_i,
  input  logic        repeat_sequence_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        pwm_enable_o,
  output logic        tick_enable_o,
  output logic [15:0] pwm_freq_hz_o,
  output logic [5:0]  duty_percent_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import bns_pkg::*;

  localparam int PW = $clog2(NOTE_DEPTH);
  localparam int CW = $clog2(NOTE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_POS = PW'(NOTE_DEPTH - 1);

  // configuration
  logic [3:0]  volume_q;
  logic [15:0] rated_q;

  // command register
  cmd_t cmd_q;
  logic cmd_vld_q;
  logic advance;

  // playback state
  status_e       status_q, status_d;
  logic [31:0]   ticks_q, ticks_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [CW-1:0] played_q, played_d;
  logic [CW-1:0] count_q, count_d;
  logic          repeat_q, repeat_d;
  logic [15:0]   freq_q, freq_d;
  logic [5:0]    duty_q, duty_d;

  // note memory
  logic [31:0]   note_mem [NOTE_DEPTH];
  logic [31:0]   rd_next_q, rd_zero_q;
  logic          note_we;
  logic [PW-1:0] note_waddr;
  logic [31:0]   note_wdata;
  logic [PW-1:0] next_addr;

  // note application
  logic          apply;
  logic [31:0]   note_src;
  logic [5:0]    note_duty;
  logic [15:0]   note_freq;
  logic [15:0]   note_ms;
  logic [15:0]   freq_op;
  logic [31:0]   budget;
  logic [4:0]    len_c;
  logic [CW-1:0] len_sat;

  // result register
  logic        out_vld_q;
  logic        pwm_en_q, tick_en_q;
  logic [15:0] out_freq_q;
  logic [5:0]  out_duty_q;
  logic [1:0]  out_status_q;

  assign advance     = cmd_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !cmd_vld_q || advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q <= VOLUME_RESET;
      rated_q  <= RATED_FREQ_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_VOLUME:     volume_q <= cfg_data_i[3:0];
        CFG_RATED_FREQ: rated_q  <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      cmd_vld_q <= 1'b1;
    end else if (advance) begin
      cmd_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q.mode            <= mode_i;
      cmd_q.freq_hz         <= freq_hz_i;
      cmd_q.duration_ms     <= duration_ms_i;
      cmd_q.tone_volume     <= tone_volume_i;
      cmd_q.note_index      <= note_index_i;
      cmd_q.sequence_length <= sequence_length_i;
      cmd_q.repeat_sequence <= repeat_sequence_i;
    end
  end

  // sequence length: zero plays one note, saturate at the store depth
  assign len_c   = (cmd_q.sequence_length == 5'd0) ? 5'd1 : cmd_q.sequence_length;
  assign len_sat = (32'(len_c) > NOTE_DEPTH) ? CW'(NOTE_DEPTH) : CW'(len_c);

  always_comb begin
    status_d   = status_q;
    ticks_d    = ticks_q;
    pos_d      = pos_q;
    played_d   = played_q;
    count_d    = count_q;
    repeat_d   = repeat_q;
    freq_d     = freq_q;
    duty_d     = duty_q;
    apply      = 1'b0;
    note_src   = rd_zero_q;
    note_duty  = duty_of(volume_q);
    note_we    = 1'b0;
    note_waddr = PW'(cmd_q.note_index);
    note_wdata = {cmd_q.duration_ms, cmd_q.freq_hz};

    if (advance) begin
      case (cmd_q.mode)
        MODE_TICK: begin
          if (status_q == ST_TONE || status_q == ST_SEQUENCE) begin
            if (ticks_q >= TICK_STEP) begin
              ticks_d = ticks_q - TICK_STEP;
            end else if (status_q == ST_SEQUENCE && played_q < count_q) begin
              played_d = played_q + CW'(1);
              pos_d    = (pos_q == LAST_POS) ? '0 : pos_q + PW'(1);
              note_src = rd_next_q;
              apply    = 1'b1;
            end else if (status_q == ST_SEQUENCE && repeat_q) begin
              pos_d    = '0;
              played_d = CW'(1);
              note_src = rd_zero_q;
              apply    = 1'b1;
            end else begin
              status_d = ST_STOPPED;
              ticks_d  = '0;
              pos_d    = '0;
              played_d = '0;
              count_d  = '0;
              repeat_d = 1'b0;
            end
          end
        end
        MODE_TONE: begin
          status_d  = ST_TONE;
          pos_d     = '0;
          played_d  = '0;
          count_d   = '0;
          repeat_d  = 1'b0;
          note_src  = {cmd_q.duration_ms, cmd_q.freq_hz};
          note_duty = duty_of(cmd_q.tone_volume);
          apply     = 1'b1;
        end
        MODE_LOAD_NOTE: begin
          note_we = (32'(cmd_q.note_index) < NOTE_DEPTH);
        end
        MODE_SEQUENCE: begin
          status_d = ST_SEQUENCE;
          count_d  = len_sat;
          repeat_d = cmd_q.repeat_sequence;
          pos_d    = '0;
          played_d = CW'(1);
          note_src = rd_zero_q;
          apply    = 1'b1;
        end
        MODE_STOP: begin
          status_d = ST_STOPPED;
          ticks_d  = '0;
          pos_d    = '0;
          played_d = '0;
          count_d  = '0;
          repeat_d = 1'b0;
        end
        MODE_MAX_POWER: begin
          status_d = ST_MAX_POWER;
          ticks_d  = '0;
          pos_d    = '0;
          played_d = '0;
          count_d  = '0;
          repeat_d = 1'b0;
          freq_d   = rated_q;
          duty_d   = DUTY_FULL;
        end
        default: ;
      endcase
    end

    // A rest runs at 1000 Hz, so ms ticks equal 1000*ms of budget like any tone.
    note_freq = note_src[15:0];
    note_ms   = note_src[31:16];
    freq_op   = (note_freq == '0) ? REST_FREQ : note_freq;
    budget    = 32'(freq_op) * 32'(note_ms);

    if (apply) begin
      freq_d  = freq_op;
      duty_d  = (note_freq == '0) ? '0 : note_duty;
      ticks_d = budget;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ST_STOPPED;
      ticks_q  <= '0;
      pos_q    <= '0;
      played_q <= '0;
      count_q  <= '0;
      repeat_q <= 1'b0;
      freq_q   <= '0;
      duty_q   <= '0;
    end else begin
      status_q <= status_d;
      ticks_q  <= ticks_d;
      pos_q    <= pos_d;
      played_q <= played_d;
      count_q  <= count_d;
      repeat_q <= repeat_d;
      freq_q   <= freq_d;
      duty_q   <= duty_d;
    end
  end

  // Prefetch the entry after the next position and entry zero; bypass a same-cycle load.
  assign next_addr = (pos_d == LAST_POS) ? '0 : pos_d + PW'(1);

  always_ff @(posedge clk_i) begin
    if (note_we) begin
      note_mem[note_waddr] <= note_wdata;
    end
    rd_next_q <= (note_we && note_waddr == next_addr) ? note_wdata : note_mem[next_addr];
    rd_zero_q <= (note_we && note_waddr == '0) ? note_wdata : note_mem[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pwm_en_q     <= (status_d != ST_STOPPED);
      tick_en_q    <= (status_d == ST_TONE || status_d == ST_SEQUENCE);
      out_freq_q   <= freq_d;
      out_duty_q   <= duty_d;
      out_status_q <= status_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign pwm_enable_o   = pwm_en_q;
  assign tick_enable_o  = tick_en_q;
  assign pwm_freq_hz_o  = out_freq_q;
  assign duty_percent_o = out_duty_q;
  assign status_o       = out_status_q;

endmodule

>>> tb/buzzer_note_sequencer_checker.sv
// Checker for the buzzer note sequencer: predicts PWM settings per command and compares results.
`timescale 1ns / 1ps

module buzzer_note_sequencer_checker #(
  parameter int NOTE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [15:0] freq_hz_i,
  input  logic [15:0] duration_ms_i,
  input  logic [3:0]  tone_volume_i,
  input  logic [3:0]  note_index_i,
  input  logic [4:0]  sequence_length_i,
  input  logic        repeat_sequence_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic        pwm_enable_o,
  input  logic        tick_enable_o,
  input  logic [15:0] pwm_freq_hz_o,
  input  logic [5:0]  duty_percent_o,
  input  logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          in_flight_o
);

  import bns_pkg::*;

  typedef struct packed {
    logic        pwm_enable;
    logic        tick_enable;
    logic [15:0] pwm_freq_hz;
    logic [5:0]  duty_percent;
    logic [1:0]  status;
  } pwm_result_t;

  localparam logic [31:0] MS_PER_SECOND = 32'd1000;
  localparam logic [3:0]  VOLUME_TOP    = 4'd8;
  // duty percent per volume index, index 0 in the low six bits
  localparam logic [53:0] DUTY_LUT = {6'd50, 6'd28, 6'd20, 6'd14, 6'd10,
                                      6'd8, 6'd5, 6'd3, 6'd0};

  logic [31:0] note_mem [NOTE_DEPTH];
  status_e     play_st;
  logic [31:0] ticks_left;
  int          note_pos;
  int          notes_played;
  int          seq_count;
  logic        repeat_on;
  logic [15:0] cur_freq;
  logic [5:0]  cur_duty;
  logic [3:0]  vol_reg;
  logic [15:0] rated_reg;

  pwm_result_t pwm_expected_q [$];
  int          errors;

  function automatic logic [5:0] volume_duty(input logic [3:0] vol);
    logic [3:0] idx;
    idx = (vol > VOLUME_TOP) ? VOLUME_TOP : vol;
    return DUTY_LUT[idx*6 +: 6];
  endfunction

  task automatic start_note(input logic [15:0] f, input logic [15:0] ms,
                            input logic [5:0] duty);
    if (f != 16'd0) begin
      cur_freq   = f;
      cur_duty   = duty;
      ticks_left = ({16'd0, f} * {16'd0, ms}) / MS_PER_SECOND;
    end else begin
      cur_freq   = REST_FREQ;
      cur_duty   = 6'd0;
      ticks_left = {16'd0, ms};
    end
  endtask

  task automatic start_stored_note();
    logic [31:0] entry;
    entry = note_mem[note_pos];
    start_note(entry[15:0], entry[31:16], volume_duty(vol_reg));
  endtask

  task automatic clear_playback();
    play_st      = ST_STOPPED;
    ticks_left   = '0;
    note_pos     = 0;
    notes_played = 0;
    seq_count    = 0;
    repeat_on    = 1'b0;
  endtask

  task automatic step_playback(input cmd_t c, output pwm_result_t r);
    int len;
    case (c.mode)
      MODE_TICK: begin
        if (play_st == ST_TONE || play_st == ST_SEQUENCE) begin
          if (ticks_left != 0) begin
            ticks_left = ticks_left - 1;
          end else if (play_st == ST_SEQUENCE && notes_played < seq_count) begin
            notes_played++;
            note_pos = (note_pos + 1) % NOTE_DEPTH;
            start_stored_note();
          end else if (play_st == ST_SEQUENCE && repeat_on) begin
            note_pos     = 0;
            notes_played = 1;
            start_stored_note();
          end else begin
            clear_playback();
          end
        end
      end
      MODE_TONE: begin
        clear_playback();
        start_note(c.freq_hz, c.duration_ms, volume_duty(c.tone_volume));
        play_st = ST_TONE;
      end
      MODE_LOAD_NOTE: begin
        if (int'(c.note_index) < NOTE_DEPTH)
          note_mem[c.note_index] = {c.duration_ms, c.freq_hz};
      end
      MODE_SEQUENCE: begin
        len = c.sequence_length;
        if (len == 0) len = 1;
        if (len > NOTE_DEPTH) len = NOTE_DEPTH;
        seq_count    = len;
        repeat_on    = c.repeat_sequence;
        note_pos     = 0;
        notes_played = 1;
        start_stored_note();
        play_st = ST_SEQUENCE;
      end
      MODE_STOP: clear_playback();
      MODE_MAX_POWER: begin
        clear_playback();
        cur_freq = rated_reg;
        cur_duty = DUTY_FULL;
        play_st  = ST_MAX_POWER;
      end
      default: ;
    endcase
    r.pwm_enable   = (play_st != ST_STOPPED);
    r.tick_enable  = (play_st == ST_TONE || play_st == ST_SEQUENCE);
    r.pwm_freq_hz  = cur_freq;
    r.duty_percent = cur_duty;
    r.status       = play_st;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t        cmd;
    pwm_result_t want;
    pwm_result_t got;
    if (!rst_ni) begin
      clear_playback();
      cur_freq  = '0;
      cur_duty  = '0;
      vol_reg   = VOLUME_RESET;
      rated_reg = RATED_FREQ_RESET;
      pwm_expected_q.delete();
      errors = 0;
      fail_count_o <= 0;
      in_flight_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_VOLUME) vol_reg = cfg_data_i[3:0];
        else rated_reg = cfg_data_i;
      end
      if (in_valid_i && in_ready_o) begin
        cmd.mode            = mode_i;
        cmd.freq_hz         = freq_hz_i;
        cmd.duration_ms     = duration_ms_i;
        cmd.tone_volume     = tone_volume_i;
        cmd.note_index      = note_index_i;
        cmd.sequence_length = sequence_length_i;
        cmd.repeat_sequence = repeat_sequence_i;
        step_playback(cmd, want);
        pwm_expected_q.push_back(want);
      end
      if (out_valid_o && out_ready_i) begin
        got = {pwm_enable_o, tick_enable_o, pwm_freq_hz_o, duty_percent_o, status_o};
        if (pwm_expected_q.size() == 0) begin
          errors++;
          $error("result transfer with no command outstanding (status %0d)", got.status);
        end else begin
          want = pwm_expected_q.pop_front();
          if (got.pwm_enable !== want.pwm_enable) begin
            errors++;
            $error("pwm_enable expected %0d got %0d", want.pwm_enable, got.pwm_enable);
          end
          if (got.tick_enable !== want.tick_enable) begin
            errors++;
            $error("tick_enable expected %0d got %0d", want.tick_enable, got.tick_enable);
          end
          if (got.pwm_freq_hz !== want.pwm_freq_hz) begin
            errors++;
            $error("pwm_freq_hz expected %0d got %0d", want.pwm_freq_hz, got.pwm_freq_hz);
          end
          if (got.duty_percent !== want.duty_percent) begin
            errors++;
            $error("duty_percent expected %0d got %0d", want.duty_percent, got.duty_percent);
          end
          if (got.status !== want.status) begin
            errors++;
            $error("status expected %0d got %0d", want.status, got.status);
          end
        end
      end
      fail_count_o <= errors;
      in_flight_o  <= pwm_expected_q.size();
    end
  end

endmodule

>>> tb/buzzer_note_sequencer_tb.sv
// Testbench top for the buzzer note sequencer: stimulus, handshake idling and verdict.
`timescale 1ns / 1ps

module buzzer_note_sequencer_tb;

  import bns_pkg::*;

  localparam int          NOTE_DEPTH       = 16;
  localparam int          PHASES           = 6;
  localparam int          RANDOM_PER_PHASE = 230;
  localparam int          MAX_GAP          = 19;
  localparam int          DRAIN_SETTLE     = 4;
  localparam int          END_SETTLE       = 8;
  localparam int          TIMEOUT_NS       = 1_000_000;
  localparam logic [2:0]  MODE_UNDEF_A     = 3'd6;
  localparam logic [2:0]  MODE_UNDEF_B     = 3'd7;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        in_valid_i        = 1'b0;
  logic        in_ready_o;
  logic [2:0]  mode_i            = MODE_TICK;
  logic [15:0] freq_hz_i         = '0;
  logic [15:0] duration_ms_i     = '0;
  logic [3:0]  tone_volume_i     = '0;
  logic [3:0]  note_index_i      = '0;
  logic [4:0]  sequence_length_i = '0;
  logic        repeat_sequence_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i       = 1'b0;
  logic        pwm_enable_o;
  logic        tick_enable_o;
  logic [15:0] pwm_freq_hz_o;
  logic [5:0]  duty_percent_o;
  logic [1:0]  status_o;
  logic        cfg_valid_i       = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i       = 1'b0;
  logic [15:0] cfg_data_i        = '0;
  int          fail_count_o;
  int          in_flight_o;

  logic        quiet  = 1'b0;
  logic [15:0] loaded = '0;

  buzzer_note_sequencer #(.NOTE_DEPTH(NOTE_DEPTH)) dut (.*);

  buzzer_note_sequencer_checker #(.NOTE_DEPTH(NOTE_DEPTH)) chk (.*);

  always #1 clk_i = ~clk_i;

  initial begin
    #(TIMEOUT_NS);
    $display("buzzer_note_sequencer_tb: errors");
    $finish;
  end

  // result side: random stall before every result, none while quiet
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  function automatic cmd_t make_cmd(input logic [2:0] mode, input logic [15:0] f,
                                    input logic [15:0] ms, input logic [3:0] vol,
                                    input logic [3:0] idx, input logic [4:0] len,
                                    input logic rep);
    cmd_t c;
    c.mode            = mode;
    c.freq_hz         = f;
    c.duration_ms     = ms;
    c.tone_volume     = vol;
    c.note_index      = idx;
    c.sequence_length = len;
    c.repeat_sequence = rep;
    return c;
  endfunction

  // number of note entries loaded contiguously from entry 0
  function automatic int loaded_prefix();
    int n;
    n = 0;
    while (n < NOTE_DEPTH && loaded[n]) n++;
    return n;
  endfunction

  // mostly short notes and rests so sequences advance; now and then a long one
  function automatic void shape_note(inout cmd_t c);
    int s;
    s = $urandom_range(0, 99);
    if (s < 35) begin
      c.freq_hz     = '0;
      c.duration_ms = 16'($urandom_range(0, 4));
    end else if (s < 90) begin
      c.freq_hz     = 16'($urandom_range(1, 3000));
      c.duration_ms = 16'($urandom_range(0, 3));
    end else if (s < 95) begin
      c.duration_ms = 16'($urandom_range(0, 1));
    end
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t        c;
    logic [31:0] r1;
    logic [31:0] r2;
    int          pick;
    int          pre;
    r1 = $urandom;
    r2 = $urandom;
    c  = make_cmd(MODE_TICK, r1[15:0], r1[31:16], r2[3:0], r2[7:4], r2[12:8], r2[13]);
    pick = $urandom_range(0, 99);
    if (pick < 14) begin
      c.mode = MODE_LOAD_NOTE;
      shape_note(c);
    end else if (pick < 21) begin
      c.mode = MODE_SEQUENCE;
      pre = loaded_prefix();
      // play only entries that hold a loaded note
      if (pre < NOTE_DEPTH) c.sequence_length = 5'($urandom_range(1, pre));
    end else if (pick < 27) begin
      c.mode = MODE_TONE;
      shape_note(c);
    end else if (pick < 30) begin
      c.mode = MODE_STOP;
    end else if (pick < 33) begin
      c.mode = MODE_MAX_POWER;
    end else if (pick < 35) begin
      c.mode = r2[14] ? MODE_UNDEF_A : MODE_UNDEF_B;
    end
    return c;
  endfunction

  task automatic send_cmd(input cmd_t c);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    mode_i            <= c.mode;
    freq_hz_i         <= c.freq_hz;
    duration_ms_i     <= c.duration_ms;
    tone_volume_i     <= c.tone_volume;
    note_index_i      <= c.note_index;
    sequence_length_i <= c.sequence_length;
    repeat_sequence_i <= c.repeat_sequence;
    in_valid_i        <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (c.mode == MODE_LOAD_NOTE) loaded[c.note_index] = 1'b1;
  endtask

  // hold the command side until every result has arrived
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (in_flight_o != 0) @(posedge clk_i);
    repeat (DRAIN_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [3:0]  vol;
    logic [15:0] rated;
    logic [11:0] junk;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_cmd(make_cmd(MODE_TICK, 16'd0, 16'd0, 4'd0, 4'd0, 5'd0, 1'b0));
    send_cmd(make_cmd(MODE_MAX_POWER, 16'd0, 16'd0, 4'd0, 4'd0, 5'd0, 1'b0));
    send_cmd(make_cmd(MODE_TICK, 16'hffff, 16'hffff, 4'hf, 4'hf, 5'h1f, 1'b1));
    send_cmd(make_cmd(MODE_UNDEF_A, 16'd0, 16'd0, 4'd0, 4'd0, 5'd0, 1'b0));
    send_cmd(make_cmd(MODE_STOP, 16'd0, 16'd0, 4'd0, 4'd0, 5'd0, 1'b0));
    // longest tone at a volume past the table end
    send_cmd(make_cmd(MODE_TONE, 16'hffff, 16'hffff, 4'hf, 4'd0, 5'd0, 1'b0));
    send_cmd(make_cmd(MODE_TICK, 16'd0, 16'd0, 4'd0, 4'd0, 5'd0, 1'b0));
    send_cmd(make_cmd(MODE_UNDEF_B, 16'hffff, 16'hffff, 4'hf, 4'hf, 5'h1f, 1'b1));
    // rest as a tone, then run it out
    send_cmd(make_cmd(MODE_TONE, 16'd0, 16'd1, 4'd0, 4'd0, 5'd0, 1'b0));
    send_cmd(make_cmd(MODE_TICK, 16'd0, 16'd0, 4'd0, 4'd0, 5'd0, 1'b0));
    send_cmd(make_cmd(MODE_TICK, 16'd0, 16'd0, 4'd0, 4'd0, 5'd0, 1'b0));
    send_cmd(make_cmd(MODE_LOAD_NOTE, 16'd0, 16'd1, 4'd0, 4'd0, 5'd0, 1'b0));
    send_cmd(make_cmd(MODE_LOAD_NOTE, 16'hffff, 16'd0, 4'd0, 4'd1, 5'd0, 1'b0));
    send_cmd(make_cmd(MODE_LOAD_NOTE, 16'd1, 16'hffff, 4'd0, 4'd2, 5'd0, 1'b0));
    send_cmd(make_cmd(MODE_LOAD_NOTE, 16'd2000, 16'd1, 4'd0, 4'd3, 5'd0, 1'b0));
    // two-note loop: advance, then wrap back to entry 0
    send_cmd(make_cmd(MODE_SEQUENCE, 16'd0, 16'd0, 4'd0, 4'd0, 5'd2, 1'b1));
    send_cmd(make_cmd(MODE_TICK, 16'd0, 16'd0, 4'd0, 4'd0, 5'd0, 1'b0));
    send_cmd(make_cmd(MODE_TICK, 16'd0, 16'd0, 4'd0, 4'd0, 5'd0, 1'b0));
    send_cmd(make_cmd(MODE_TICK, 16'd0, 16'd0, 4'd0, 4'd0, 5'd0, 1'b0));
    // zero length plays one note and ends
    send_cmd(make_cmd(MODE_SEQUENCE, 16'd0, 16'd0, 4'd0, 4'd0, 5'd0, 1'b0));
    send_cmd(make_cmd(MODE_TICK, 16'd0, 16'd0, 4'd0, 4'd0, 5'd0, 1'b0));
    send_cmd(make_cmd(MODE_TICK, 16'd0, 16'd0, 4'd0, 4'd0, 5'd0, 1'b0));
    send_cmd(make_cmd(MODE_STOP, 16'd0, 16'd0, 4'd0, 4'd0, 5'd0, 1'b0));
    // product below one tick: tone ends on the first tick
    send_cmd(make_cmd(MODE_TONE, 16'd999, 16'd1, 4'd8, 4'd0, 5'd0, 1'b0));
    send_cmd(make_cmd(MODE_TICK, 16'd0, 16'd0, 4'd0, 4'd0, 5'd0, 1'b0));

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        0: begin vol = 4'd8;  rated = 16'hffff; end
        1: begin vol = 4'd0;  rated = 16'd1; end
        2: begin vol = 4'hf;  rated = 16'($urandom_range(1, 65535)); end
        default: begin
          vol   = 4'($urandom_range(0, 15));
          rated = 16'($urandom_range(1, 65535));
        end
      endcase
      junk = 12'($urandom);
      write_reg(CFG_VOLUME, {junk, vol});
      write_reg(CFG_RATED_FREQ, rated);
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        quiet <= ((k / 40) % 4 == 1);
        send_cmd(random_cmd());
      end
      quiet <= 1'b0;
    end

    drain_results();
    repeat (END_SETTLE) @(posedge clk_i);
    if (fail_count_o == 0 && in_flight_o == 0) begin
      $display("buzzer_note_sequencer_tb: clean");
    end else begin
      $display("buzzer_note_sequencer_tb: errors");
    end
    $finish;
  end

endmodule
